>>> design/pba_pkg.sv
package pba_pkg;

  // register field widths
  localparam int PL_W  = 5;
  localparam int BL_W  = 7;
  localparam int CNT_W = 7;

  localparam logic [PL_W-1:0]  PAGE_LIMIT_RST  = 5'd16;
  localparam logic [BL_W-1:0]  BLOCK_LIMIT_RST = 7'd64;
  localparam logic [CNT_W-1:0] CNT_MAX         = 7'd127;

  // configuration register indexes
  localparam logic CFG_PAGE_LIMIT  = 1'b0;
  localparam logic CFG_BLOCK_LIMIT = 1'b1;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SWEEP
  } state_t;

  // decoded request held across the read-modify-write
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_OPEN,
    OP_OOM,
    OP_FREE,
    OP_BAD
  } op_t;

endpackage

>>> design/pba_ram.sv
module pba_ram #(
  parameter int WIDTH = 71,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/pba_ffs.sv
module pba_ffs #(
  parameter int W = 64,
  localparam int IW = (W > 1) ? $clog2(W) : 1
) (
  input  logic [W-1:0]  vec,
  output logic [IW-1:0] idx,
  output logic          found
);

  // lowest set bit wins
  always_comb begin
    idx   = '0;
    found = |vec;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IW'(i);
      end
    end
  end

endmodule

>>> design/paged_bitmap_block_allocator.sv
// Paged bitmap block allocator. Each request (tuser = 0 allocate, 1 free) gives exactly one
// result: status in out_tuser, allocated page and block in out_tdata (zero for frees and
// failures). Page bitmaps and free counts live in one single-port-read RAM word per page;
// a request reads its page word in the accept cycle and modifies and writes it back once
// the result register has room; the next request is taken only after that write-back.
// Page choice for an allocate comes from a flop vector of per-page "has a usable free block"
// flags, so no page scan is needed per request. A write to block_limit invalidates those
// flags; before the next request is taken the block runs a refresh pass that reads every
// opened page once. The RAM itself has no reset and no clearing pass: a page word is written
// in full when the page is opened. Configuration writes are always accepted (cfg_ready is
// tied high) and must only arrive while idle.
module paged_bitmap_block_allocator #(
  parameter int PAGES  = 16,
  parameter int BLOCKS = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [3:0] free_page, [9:4] free_block, [15:10] zero
  input  logic        in_tuser,   // [0] kind

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] got_page, [9:4] got_block, [15:10] zero
  output logic [1:0]  out_tuser,  // [1:0] status

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int PIW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int PCW    = $clog2(PAGES + 1);
  localparam int BIW    = $clog2(BLOCKS);
  localparam int CMPW   = (PCW > pba_pkg::PL_W) ? PCW : pba_pkg::PL_W;
  localparam int WORD_W = BLOCKS + pba_pkg::CNT_W;

  // control state
  pba_pkg::state_t state_r, state_nxt;
  logic [PCW-1:0]           pages_in_use_r, pages_in_use_nxt;
  logic [pba_pkg::PL_W-1:0] page_limit_r, page_limit_nxt;
  logic [pba_pkg::BL_W-1:0] block_limit_r, block_limit_nxt;
  logic                     stale_r, stale_nxt;      // avail flags need a refresh pass
  logic [PAGES-1:0]         avail_r, avail_nxt;      // page has a free block under the limit
  logic                     out_valid_r, out_valid_nxt;
  logic                     sweep_eval_r, sweep_eval_nxt;

  // payload state
  pba_pkg::op_t    req_op_r, req_op_nxt;
  logic [PIW-1:0]  req_page_r, req_page_nxt;
  logic [BIW-1:0]  req_block_r, req_block_nxt;
  pba_pkg::status_t out_status_r, out_status_nxt;
  logic [3:0]      out_page_r, out_page_nxt;
  logic [5:0]      out_block_r, out_block_nxt;
  logic [PCW-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic [PIW-1:0]  sweep_idx_r, sweep_idx_nxt;

  // input fields
  logic       in_kind;
  logic [3:0] in_fpage;
  logic [5:0] in_fblock;
  logic       in_accept;

  assign in_kind   = in_tuser;
  assign in_fpage  = in_tdata[3:0];
  assign in_fblock = in_tdata[9:4];
  assign in_accept = in_tvalid && in_tready;

  // effective limits and usable block mask
  logic [pba_pkg::BL_W-1:0] eff_blocks;
  logic [CMPW-1:0]          eff_pages;
  logic [CMPW-1:0]          piu_ext;
  logic [BLOCKS-1:0]        mask;

  assign piu_ext = CMPW'(pages_in_use_r);

  always_comb begin
    eff_blocks = block_limit_r;
    if (block_limit_r == '0) begin
      eff_blocks = pba_pkg::BL_W'(1);
    end else if (block_limit_r > pba_pkg::BL_W'(BLOCKS)) begin
      eff_blocks = pba_pkg::BL_W'(BLOCKS);
    end
    eff_pages = CMPW'(page_limit_r);
    if (page_limit_r == '0) begin
      eff_pages = CMPW'(1);
    end else if (CMPW'(page_limit_r) > CMPW'(PAGES)) begin
      eff_pages = CMPW'(PAGES);
    end
    for (int i = 0; i < BLOCKS; i++) begin
      mask[i] = pba_pkg::BL_W'(i) < eff_blocks;
    end
  end

  // lowest available page among the opened ones
  logic [PIW-1:0] page_sel;
  logic           page_found;

  pba_ffs #(.W(PAGES)) u_page_ffs (
    .vec   (avail_r),
    .idx   (page_sel),
    .found (page_found)
  );

  // decode of an incoming request
  pba_pkg::op_t   acc_op;
  logic [PIW-1:0] acc_page;

  always_comb begin
    acc_op   = pba_pkg::OP_OOM;
    acc_page = '0;
    if (in_kind == pba_pkg::KIND_ALLOC) begin
      if (page_found) begin
        acc_op   = pba_pkg::OP_ALLOC;
        acc_page = page_sel;
      end else if (piu_ext < eff_pages) begin
        // open the next page in index order
        acc_op   = pba_pkg::OP_OPEN;
        acc_page = PIW'(pages_in_use_r);
      end
    end else begin
      acc_page = PIW'(in_fpage);
      if ((CMPW'(in_fpage) < piu_ext) && (pba_pkg::BL_W'(in_fblock) < eff_blocks)) begin
        acc_op = pba_pkg::OP_FREE;
      end else begin
        acc_op = pba_pkg::OP_BAD;
      end
    end
  end

  // page memory: {free_count, free_map}
  logic               ram_we;
  logic               ram_re;
  logic [PIW-1:0]     ram_raddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WORD_W-1:0]  ram_rdata;

  pba_ram #(.WIDTH(WORD_W), .DEPTH(PAGES)) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req_page_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [BLOCKS-1:0]         rmap;
  logic [pba_pkg::CNT_W-1:0] rcnt;

  assign rmap = ram_rdata[BLOCKS-1:0];
  assign rcnt = ram_rdata[WORD_W-1:BLOCKS];

  // modify step; a freshly opened page starts all free with a full count
  logic [BLOCKS-1:0]         src_map;
  logic [pba_pkg::CNT_W-1:0] src_cnt;
  logic [BIW-1:0]            blk_sel;
  logic                      blk_found;
  logic [BLOCKS-1:0]         alloc_map;
  logic [pba_pkg::CNT_W-1:0] alloc_cnt;
  logic [BLOCKS-1:0]         free_map;
  logic [pba_pkg::CNT_W-1:0] free_cnt;
  logic                      free_bit;

  assign src_map = (req_op_r == pba_pkg::OP_OPEN) ? '1 : rmap;
  assign src_cnt = (req_op_r == pba_pkg::OP_OPEN) ? pba_pkg::CNT_W'(eff_blocks) : rcnt;

  pba_ffs #(.W(BLOCKS)) u_block_ffs (
    .vec   (src_map & mask),
    .idx   (blk_sel),
    .found (blk_found)
  );

  assign alloc_map = src_map & ~(BLOCKS'(1) << blk_sel);
  assign alloc_cnt = (src_cnt == '0) ? '0 : src_cnt - pba_pkg::CNT_W'(1);
  assign free_bit  = rmap[req_block_r];
  assign free_map  = rmap | (BLOCKS'(1) << req_block_r);
  assign free_cnt  = (rcnt == pba_pkg::CNT_MAX) ? rcnt : rcnt + pba_pkg::CNT_W'(1);

  // next state and outputs
  always_comb begin
    state_nxt        = state_r;
    pages_in_use_nxt = pages_in_use_r;
    page_limit_nxt   = page_limit_r;
    block_limit_nxt  = block_limit_r;
    stale_nxt        = stale_r;
    avail_nxt        = avail_r;
    out_valid_nxt    = out_valid_r;
    sweep_eval_nxt   = sweep_eval_r;
    req_op_nxt       = req_op_r;
    req_page_nxt     = req_page_r;
    req_block_nxt    = req_block_r;
    out_status_nxt   = out_status_r;
    out_page_nxt     = out_page_r;
    out_block_nxt    = out_block_r;
    sweep_addr_nxt   = sweep_addr_r;
    sweep_idx_nxt    = sweep_idx_r;
    ram_we           = 1'b0;
    ram_wdata        = {alloc_cnt, alloc_map};
    ram_re           = 1'b0;
    ram_raddr        = acc_page;

    // result register drains independently of the request path
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      pba_pkg::S_IDLE: begin
        if (in_accept) begin
          req_op_nxt    = acc_op;
          req_page_nxt  = acc_page;
          req_block_nxt = BIW'(in_fblock);
          ram_re        = (acc_op == pba_pkg::OP_ALLOC) || (acc_op == pba_pkg::OP_FREE);
          state_nxt     = pba_pkg::S_RMW;
        end else if (stale_r) begin
          sweep_addr_nxt = '0;
          sweep_eval_nxt = 1'b0;
          state_nxt      = pba_pkg::S_SWEEP;
        end
      end

      pba_pkg::S_RMW: begin
        // hold the read word until the result register has room
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pba_pkg::ST_OK;
          out_page_nxt   = '0;
          out_block_nxt  = '0;
          state_nxt      = pba_pkg::S_IDLE;
          case (req_op_r)
            pba_pkg::OP_ALLOC, pba_pkg::OP_OPEN: begin
              ram_we                = 1'b1;
              ram_wdata             = {alloc_cnt, alloc_map};
              avail_nxt[req_page_r] = |(alloc_map & mask);
              out_page_nxt          = 4'(req_page_r);
              out_block_nxt         = 6'(blk_sel);
              if (req_op_r == pba_pkg::OP_OPEN) begin
                pages_in_use_nxt = pages_in_use_r + PCW'(1);
              end
            end
            pba_pkg::OP_FREE: begin
              if (free_bit) begin
                out_status_nxt = pba_pkg::ST_BAD_FREE;
              end else begin
                ram_we                = 1'b1;
                ram_wdata             = {free_cnt, free_map};
                avail_nxt[req_page_r] = 1'b1;
              end
            end
            pba_pkg::OP_OOM: begin
              out_status_nxt = pba_pkg::ST_OOM;
            end
            default: begin
              out_status_nxt = pba_pkg::ST_BAD_FREE;
            end
          endcase
        end
      end

      pba_pkg::S_SWEEP: begin
        // one read per cycle, flag evaluated as the word comes back
        sweep_eval_nxt = 1'b0;
        if (sweep_eval_r) begin
          avail_nxt[sweep_idx_r] = |(rmap & mask);
        end
        if (CMPW'(sweep_addr_r) < piu_ext) begin
          ram_re         = 1'b1;
          ram_raddr      = PIW'(sweep_addr_r);
          sweep_idx_nxt  = PIW'(sweep_addr_r);
          sweep_eval_nxt = 1'b1;
          sweep_addr_nxt = sweep_addr_r + PCW'(1);
        end else begin
          // last flag, if any, lands on this same edge
          stale_nxt = 1'b0;
          state_nxt = pba_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pba_pkg::S_IDLE;
      end
    endcase

    // configuration writes; a new block limit restarts any refresh pass
    if (cfg_valid) begin
      case (cfg_index)
        pba_pkg::CFG_PAGE_LIMIT: begin
          page_limit_nxt = cfg_data[pba_pkg::PL_W-1:0];
        end
        pba_pkg::CFG_BLOCK_LIMIT: begin
          block_limit_nxt = cfg_data;
          stale_nxt       = 1'b1;
          if (state_r == pba_pkg::S_SWEEP) begin
            state_nxt = pba_pkg::S_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= pba_pkg::S_IDLE;
      pages_in_use_r <= '0;
      page_limit_r   <= pba_pkg::PAGE_LIMIT_RST;
      block_limit_r  <= pba_pkg::BLOCK_LIMIT_RST;
      stale_r        <= 1'b0;
      avail_r        <= '0;
      out_valid_r    <= 1'b0;
      sweep_eval_r   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      pages_in_use_r <= pages_in_use_nxt;
      page_limit_r   <= page_limit_nxt;
      block_limit_r  <= block_limit_nxt;
      stale_r        <= stale_nxt;
      avail_r        <= avail_nxt;
      out_valid_r    <= out_valid_nxt;
      sweep_eval_r   <= sweep_eval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_op_r     <= req_op_nxt;
    req_page_r   <= req_page_nxt;
    req_block_r  <= req_block_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_block_r  <= out_block_nxt;
    sweep_addr_r <= sweep_addr_nxt;
    sweep_idx_r  <= sweep_idx_nxt;
  end

  // ports
  assign in_tready  = (state_r == pba_pkg::S_IDLE) && !stale_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_block_r, out_page_r};
  assign out_tuser  = out_status_r;
  assign cfg_ready  = 1'b1;

  // an accepted request always goes to the read-modify-write step
  a_accept_to_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == pba_pkg::S_RMW))
    else $error("accepted request did not enter read-modify-write");

  // only opened pages may be flagged as having free blocks
  a_avail_opened: assert property (@(posedge clk) disable iff (!rst_n)
    (avail_r >> pages_in_use_r) == '0)
    else $error("free flag set on an unopened page");

  // a page picked for allocation really has a usable free block
  a_alloc_finds_block: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == pba_pkg::S_RMW) &&
     ((req_op_r == pba_pkg::OP_ALLOC) || (req_op_r == pba_pkg::OP_OPEN))) |-> blk_found)
    else $error("allocation chose a page with no usable free block");

  // completing a request loads the result register and returns to idle
  a_rmw_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == pba_pkg::S_RMW) && (!out_valid_r || out_tready)) |=>
    (out_valid_r && (state_r == pba_pkg::S_IDLE)))
    else $error("request completed without a result");

endmodule

>>> sim/pba_alloc_checker.sv
`timescale 1ns / 1ps

module pba_alloc_checker (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,

  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [1:0]  out_tuser,

  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,

  output int          mismatches,
  output int          grants_waiting,
  output int          n_granted,
  output int          n_oom,
  output int          n_released,
  output int          n_bad_free
);

  localparam int PAGES  = 16;
  localparam int BLOCKS = 64;

  typedef struct packed {
    pba_pkg::status_t status;
    logic [3:0]       page;
    logic [5:0]       block;
  } grant_t;

  grant_t grant_q[$];

  // shadow of the allocator state
  logic [63:0]               page_map   [PAGES];
  logic [pba_pkg::CNT_W-1:0] page_avail [PAGES];
  logic                      page_open  [PAGES];
  int unsigned               open_pages;
  logic [pba_pkg::PL_W-1:0]  page_limit_r;
  logic [pba_pkg::BL_W-1:0]  block_limit_r;

  initial begin
    mismatches     = 0;
    grants_waiting = 0;
    n_granted      = 0;
    n_oom          = 0;
    n_released     = 0;
    n_bad_free     = 0;
  end

  function automatic int unsigned usable_pages();
    int unsigned v;
    v = 32'(page_limit_r);
    if (v == 0) v = 1;
    if (v > PAGES) v = PAGES;
    return v;
  endfunction

  function automatic int unsigned usable_blocks();
    int unsigned v;
    v = 32'(block_limit_r);
    if (v == 0) v = 1;
    if (v > BLOCKS) v = BLOCKS;
    return v;
  endfunction

  // applies one request to the shadow state and returns the grant it produces
  function automatic grant_t serve_request(logic kind, logic [3:0] pg, logic [5:0] blk);
    grant_t      g;
    logic [63:0] mask;
    logic [63:0] avail;
    int unsigned nb;
    int          p;
    int          b;
    bit          found;
    g     = '{status: pba_pkg::ST_OK, page: '0, block: '0};
    nb    = usable_blocks();
    mask  = (nb >= 64) ? '1 : ((64'd1 << nb) - 64'd1);
    found = 1'b0;
    p     = 0;
    b     = 0;
    if (kind == pba_pkg::KIND_ALLOC) begin
      for (int i = 0; i < PAGES && i < open_pages; i++) begin
        if (!found && page_open[i] && (page_map[i] & mask) != '0) begin
          found = 1'b1;
          p     = i;
        end
      end
      if (!found) begin
        if (open_pages < usable_pages()) begin
          p             = open_pages;
          page_open[p]  = 1'b1;
          page_map[p]   = '1;
          page_avail[p] = nb[pba_pkg::CNT_W-1:0];
          open_pages++;
          found         = 1'b1;
        end else begin
          g.status = pba_pkg::ST_OOM;
        end
      end
      if (found) begin
        avail = page_map[p] & mask;
        for (int k = 63; k >= 0; k--) begin
          if (avail[k]) b = k;
        end
        page_map[p][b] = 1'b0;
        if (page_avail[p] != '0) page_avail[p] = page_avail[p] - pba_pkg::CNT_W'(1);
        g.page  = p[3:0];
        g.block = b[5:0];
      end
    end else begin
      if (!page_open[pg] || 32'(blk) >= nb || page_map[pg][blk]) begin
        g.status = pba_pkg::ST_BAD_FREE;
      end else begin
        page_map[pg][blk] = 1'b1;
        if (page_avail[pg] != pba_pkg::CNT_MAX) begin
          page_avail[pg] = page_avail[pg] + pba_pkg::CNT_W'(1);
        end
      end
    end
    return g;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ERROR: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    grant_t exp_g;
    grant_t new_g;
    if (!rst_n) begin
      for (int i = 0; i < PAGES; i++) begin
        page_map[i]   = '1;
        page_avail[i] = '0;
        page_open[i]  = 1'b0;
      end
      open_pages    = 0;
      page_limit_r  = pba_pkg::PAGE_LIMIT_RST;
      block_limit_r = pba_pkg::BLOCK_LIMIT_RST;
      grant_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pba_pkg::CFG_PAGE_LIMIT:  page_limit_r  = cfg_data[pba_pkg::PL_W-1:0];
          pba_pkg::CFG_BLOCK_LIMIT: block_limit_r = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        new_g = serve_request(in_tuser, in_tdata[3:0], in_tdata[9:4]);
        grant_q.push_back(new_g);
        if (in_tuser == pba_pkg::KIND_ALLOC) begin
          if (new_g.status == pba_pkg::ST_OK) n_granted++;
          else n_oom++;
        end else begin
          if (new_g.status == pba_pkg::ST_OK) n_released++;
          else n_bad_free++;
        end
      end
      // a result can never belong to a request taken on the same edge
      if (out_tvalid && out_tready) begin
        if (grant_q.size() == 0) begin
          flag_error($sformatf("unexpected result status %0d page %0d block %0d",
                               out_tuser, out_tdata[3:0], out_tdata[9:4]));
        end else begin
          exp_g = grant_q.pop_front();
          if (out_tuser !== exp_g.status || out_tdata[3:0] !== exp_g.page ||
              out_tdata[9:4] !== exp_g.block || out_tdata[15:10] !== 6'd0) begin
            flag_error($sformatf({"result mismatch: expected status %0d page %0d block %0d,",
                                  " got status %0d page %0d block %0d pad %0h"},
                                 exp_g.status, exp_g.page, exp_g.block,
                                 out_tuser, out_tdata[3:0], out_tdata[9:4],
                                 out_tdata[15:10]));
          end
        end
      end
    end
    grants_waiting = grant_q.size();
  end

endmodule

>>> sim/tb_paged_bitmap_block_allocator.sv
`timescale 1ns / 1ps

module tb_paged_bitmap_block_allocator;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;    // settle time before a register write

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [3:0] free_page, [9:4] free_block, [15:10] zero
  logic        in_tuser;   // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;  // [3:0] got_page, [9:4] got_block, [15:10] zero
  logic [1:0]  out_tuser;  // [1:0] status
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [6:0]  cfg_data;

  int mismatches;
  int grants_waiting;
  int n_granted;
  int n_oom;
  int n_released;
  int n_bad_free;

  // stimulus bookkeeping
  int cycle_count = 0;
  int cfg_writes  = 0;
  int phases_run  = 0;
  int hold_req    = 0;
  int hold_done   = 0;
  bit no_idle     = 1'b0;  // when set neither side inserts random gaps
  int stall_left  = 0;

  always #2 clk = ~clk;

  paged_bitmap_block_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pba_alloc_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .grants_waiting (grants_waiting),
    .n_granted      (n_granted),
    .n_oom          (n_oom),
    .n_released     (n_released),
    .n_bad_free     (n_bad_free)
  );

  // gap length: mostly none, some short, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random stalls plus the requested long hold-off, one decision per cycle
  always @(negedge clk) begin
    if (stall_left == 0) begin
      if (hold_req != hold_done) begin
        stall_left = HOLD_CYCLES;
        hold_done  = hold_done + 1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = idle_gap();
      end
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               grants_waiting);
      $display("tb_paged_bitmap_block_allocator failed");
      $finish;
    end
  end

  // one request transaction; called and returns at a falling edge
  task automatic send_req(input logic kind, input logic [3:0] pg, input logic [5:0] blk);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, blk, pg};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    @(negedge clk);
  endtask

  // every outstanding result back, then a few quiet cycles
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (grants_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limits(input logic [4:0] pl, input logic [6:0] bl);
    wait_idle();
    write_reg(pba_pkg::CFG_PAGE_LIMIT, {2'b00, pl});
    write_reg(pba_pkg::CFG_BLOCK_LIMIT, bl);
    cfg_valid <= 1'b0;
  endtask

  // random requests under one setting of the limits
  task automatic run_phase(input logic [4:0] pl, input logic [6:0] bl, input int n,
                           input int alloc_pct, input bit hold);
    int   epl;
    int   ebl;
    logic kind;
    logic [3:0] pg;
    logic [5:0] blk;
    write_limits(pl, bl);
    epl = (pl == 5'd0) ? 1 : ((pl > 5'd16) ? 16 : int'(32'(pl)));
    ebl = (bl == 7'd0) ? 1 : ((bl > 7'd64) ? 64 : int'(32'(bl)));
    no_idle = ($urandom_range(0, 3) == 0);
    if (hold) hold_req = hold_req + 1;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) no_idle = !no_idle;
      kind = ($urandom_range(0, 99) < alloc_pct) ? pba_pkg::KIND_ALLOC : pba_pkg::KIND_FREE;
      // frees mostly aim at pages and blocks that can be live, the rest is noise
      if ($urandom_range(0, 9) < 7) pg = 4'($urandom_range(0, (epl > 6) ? 5 : epl - 1));
      else pg = 4'($urandom);
      if ($urandom_range(0, 9) < 8) blk = 6'($urandom_range(0, ebl - 1));
      else blk = 6'($urandom);
      send_req(kind, pg, blk);
    end
    phases_run++;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = pba_pkg::KIND_ALLOC;
    cfg_valid  = 1'b0;
    cfg_index  = pba_pkg::CFG_PAGE_LIMIT;
    cfg_data   = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limits: first page opens, reuse of a freed block, double free,
    // free of an unopened page, free with extreme fields
    send_req(pba_pkg::KIND_ALLOC, 4'd0, 6'd0);
    send_req(pba_pkg::KIND_ALLOC, 4'd0, 6'd0);
    send_req(pba_pkg::KIND_ALLOC, 4'd15, 6'd63);
    send_req(pba_pkg::KIND_FREE, 4'd0, 6'd1);
    send_req(pba_pkg::KIND_FREE, 4'd0, 6'd1);
    send_req(pba_pkg::KIND_FREE, 4'd5, 6'd0);
    send_req(pba_pkg::KIND_FREE, 4'd15, 6'd63);
    send_req(pba_pkg::KIND_FREE, 4'd0, 6'd63);
    send_req(pba_pkg::KIND_ALLOC, 4'd0, 6'd0);

    // zero limits act as one: out of memory, free above the block limit
    write_limits(5'd0, 7'd0);
    send_req(pba_pkg::KIND_ALLOC, 4'd0, 6'd0);
    send_req(pba_pkg::KIND_FREE, 4'd0, 6'd2);
    send_req(pba_pkg::KIND_FREE, 4'd0, 6'd0);
    send_req(pba_pkg::KIND_ALLOC, 4'd0, 6'd0);
    send_req(pba_pkg::KIND_ALLOC, 4'd0, 6'd0);

    // a second page opens, then the page limit is reached
    write_limits(5'd2, 7'd1);
    send_req(pba_pkg::KIND_ALLOC, 4'd0, 6'd0);
    send_req(pba_pkg::KIND_ALLOC, 4'd0, 6'd0);

    // page limit below the opened pages, block limit above the maximum
    write_limits(5'd1, 7'd127);
    send_req(pba_pkg::KIND_ALLOC, 4'd0, 6'd0);
    send_req(pba_pkg::KIND_FREE, 4'd1, 6'd0);
    send_req(pba_pkg::KIND_ALLOC, 4'd0, 6'd0);
    send_req(pba_pkg::KIND_FREE, 4'd1, 6'd0);
    phases_run++;

    // random phases, small limits first so that pages fill up
    run_phase(5'd3, 7'd4, 60, 70, 1'b0);
    run_phase(5'd2, 7'd127, 50, 40, 1'b1);
    run_phase(5'd31, 7'd6, 80, 75, 1'b0);
    run_phase(5'd1, 7'd1, 50, 50, 1'b0);
    run_phase(5'd16, 7'd64, 80, 55, 1'b1);
    run_phase(5'd0, 7'd3, 60, 65, 1'b0);
    run_phase(5'd8, 7'd2, 80, 60, 1'b0);
    run_phase(5'd31, 7'd127, 90, 50, 1'b0);

    wait_idle();
    repeat (20) @(negedge clk);

    $display("covered %0d grants, %0d out-of-memory, %0d frees, %0d bad frees",
             n_granted, n_oom, n_released, n_bad_free);
    $display("over %0d phases with %0d register writes and %0d long receiver hold-offs",
             phases_run, cfg_writes, hold_done);
    if (mismatches == 0) begin
      $display("tb_paged_bitmap_block_allocator passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_paged_bitmap_block_allocator failed");
    end
    $finish;
  end

endmodule
